// ===== rtl/pre_pkg.sv =====
// package for the prewitt rgb edge magnitude block
// shared types and constants; no dependencies
package pre_pkg;

   localparam int PIX_W = 24;
   localparam int ROW_W = 12;
   localparam int COL_W = 10;
   localparam int SUM_W = 17;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ROOT,
      ST_SEND
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic rd_stores;
      logic start_root;
      logic root_step;
      logic commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic emit;
      logic root_done;
   } sts_type;

endpackage

// ===== rtl/prewitt_rgb_edge_magnitude.sv =====
// top level of the prewitt rgb edge magnitude block
// depends on pre_pkg, pre_ctrl, pre_dp
//
// channel  | handshake          | payload
// req      | req_tvalid/tready  | tdata: red_in, green_in, blue_in
// rsp      | rsp_tvalid/tready  | tdata: edges, out_row, out_col; tlast: frame_end
// csr      | csr_we             | csr_index, csr_wdata
//
// a request without a result goes back to idle after the line store read and write;
// one with a result also runs the 8-step serial square root and then waits on output.
// line stores: one read port per request, written in the cycle after the read.
// reset is synchronous; the line stores are not cleared. a result holds until rsp_tready.
module prewitt_rgb_edge_magnitude #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_edge, green_edge, blue_edge, out_row, out_col
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import pre_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [23:0] px;

   // datapath keeps red in the top byte of a pixel
   assign px = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   pre_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   // datapath already packs red_edge in the lowest byte
   pre_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock, .reset, .req_tdata(px), .csr_we, .csr_index, .csr_wdata,
      .cmd, .sts, .rsp_tdata, .rsp_tlast
   );
endmodule

// ===== rtl/pre_ctrl.sv =====
// controller for the prewitt edge block
// depends on pre_pkg
module pre_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  pre_pkg::sts_type  sts,
   output pre_pkg::cmd_type  cmd
);
   import pre_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_READ;
         ST_READ: state_in = sts.emit ? ST_ROOT : ST_IDLE;
         ST_ROOT: if (sts.root_done) state_in = ST_SEND;
         ST_SEND: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.rd_stores = req_tvalid;
         end
         ST_READ: begin
            cmd.start_root = 1'b1;
            cmd.commit = 1'b1;
         end
         ST_ROOT: cmd.root_step = 1'b1;
         ST_SEND: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ===== rtl/pre_dp.sv =====
// datapath: line stores, window, gradients, serial square roots, counters
// depends on pre_pkg
module pre_dp #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       req_tdata,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [12:0]       csr_wdata,
   input  pre_pkg::cmd_type  cmd,
   output pre_pkg::sts_type  sts,
   output logic [47:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import pre_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff, mid_rd_ff, px_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [12:0] row_ff;
   logic [10:0] col_ff;
   logic [AW-1:0] idx;
   logic [12:0] eff_w, eff_h;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective clamped sizes
   always_comb begin
      eff_w = {2'b0, width_ff};
      if (eff_w < 13'd3) eff_w = 13'd3;
      if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
      eff_h = height_ff;
      if (eff_h < 13'd3) eff_h = 13'd3;
      if (eff_h > 13'd4096) eff_h = 13'd4096;
   end

   assign idx = col_ff[AW-1:0];

   // line store reads and pixel capture
   always_ff @(posedge clock) begin
      if (cmd.rd_stores) begin
         up_rd_ff  <= upper_mem[idx];
         mid_rd_ff <= middle_mem[idx];
         px_ff     <= req_tdata;
      end
   end

   // line store writes
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         upper_mem[idx]  <= mid_rd_ff;
         middle_mem[idx] <= px_ff;
      end
   end

   // emission decision
   logic emit, inner, last;
   assign emit  = (row_ff != 13'd0) && (col_ff != 11'd0);
   assign inner = (row_ff != 13'd1) && (col_ff != 11'd1) &&
                  (row_ff < eff_h) && ({2'b0, col_ff} < eff_w);
   assign last  = (row_ff == eff_h - 13'd1) && ({2'b0, col_ff} == eff_w - 13'd1);

   // gradient sum per channel
   function automatic logic [SUM_W-1:0] grad_sq(
      input logic [PIX_W-1:0] c0t, c0m, c0b, c1t, c1b, c2t, c2m, c2b,
      input int sh);
      logic signed [11:0] gx, gy;
      logic signed [21:0] gx_w, gy_w;
      logic [21:0] s;
      begin
         gx = 12'(c2t[sh+:8]) + 12'(c2m[sh+:8]) + 12'(c2b[sh+:8])
            - 12'(c0t[sh+:8]) - 12'(c0m[sh+:8]) - 12'(c0b[sh+:8]);
         gy = 12'(c0b[sh+:8]) + 12'(c1b[sh+:8]) + 12'(c2b[sh+:8])
            - 12'(c0t[sh+:8]) - 12'(c1t[sh+:8]) - 12'(c2t[sh+:8]);
         // widen before squaring so the products keep all their bits
         gx_w = 22'(gx);
         gy_w = 22'(gy);
         s = 22'(gx_w * gx_w + gy_w * gy_w);
         grad_sq = (s >= 22'd65536) ? 17'h1ffff : s[SUM_W-1:0];
      end
   endfunction

   // serial root: one result bit per cycle over 8 bits (value saturated)
   logic [SUM_W-1:0] sq_ff [3];
   logic [7:0] root_ff [3];
   logic [7:0] bit_ff;
   logic inner_ff, last_ff;
   logic [11:0] orow_ff;
   logic [9:0] ocol_ff;

   assign sts = '{emit: emit, root_done: bit_ff[0]};

   always_ff @(posedge clock) begin
      if (cmd.start_root) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= grad_sq(win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[5],
                                up_rd_ff, mid_rd_ff, px_ff, 16 - 8 * k);
            root_ff[k] <= 8'd0;
         end
         bit_ff   <= 8'h80;
         inner_ff <= inner;
         last_ff  <= last;
         orow_ff  <= 12'(row_ff - 13'd1);
         ocol_ff  <= 10'(col_ff - 11'd1);
      end else if (cmd.root_step) begin
         for (int k = 0; k < 3; k++) begin
            if (sq_ff[k][16] ||
                (16'(root_ff[k] | bit_ff) * 16'(root_ff[k] | bit_ff) <= sq_ff[k][15:0]))
               root_ff[k] <= root_ff[k] | bit_ff;
         end
         bit_ff <= bit_ff >> 1;
      end
   end

   // window shift and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) win_ff[k] <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.commit) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_rd_ff;
         win_ff[4] <= mid_rd_ff;
         win_ff[5] <= px_ff;
         if ({2'b0, col_ff} + 13'd1 >= eff_w) begin
            col_ff <= '0;
            row_ff <= (row_ff + 13'd1 >= eff_h) ? 13'd0 : row_ff + 13'd1;
         end else begin
            col_ff <= col_ff + 11'd1;
         end
      end
   end

   // result packing
   assign rsp_tdata = {2'b0, ocol_ff, orow_ff,
                       inner_ff ? root_ff[2] : 8'd0,
                       inner_ff ? root_ff[1] : 8'd0,
                       inner_ff ? root_ff[0] : 8'd0};
   assign rsp_tlast = last_ff;
endmodule

// ===== rtl/pre_check.sv =====
// port checker for the prewitt edge block, bound to the top level
// depends on prewitt_rgb_edge_magnitude
module pre_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);
   // a pending result holds steady
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // no request taken while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request taken with result pending");
   // a result never follows directly on acceptance
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result too early");
   // the top border row gives zero edges
   a_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35:24] == 12'd0 |-> rsp_tdata[23:0] == 24'd0)
      else $error("nonzero edge on top row");
   // frame end flag is driven whenever a result is offered
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tlast))
      else $error("frame end unknown on a result");
endmodule

bind prewitt_rgb_edge_magnitude pre_check u_check (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);

// ===== tb/prewitt_edge_checker.sv =====
// checker for the prewitt rgb edge magnitude block: watches requests, register
// writes and results, predicts every edge result and compares it field by field
// depends on pre_pkg for the register indexes
module prewitt_edge_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // red_edge, green_edge, blue_edge, out_row, out_col
   input  logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          frame_end_count
);
   import pre_pkg::*;

   typedef struct {
      logic [7:0]  red_edge;
      logic [7:0]  green_edge;
      logic [7:0]  blue_edge;
      logic [11:0] out_row;
      logic [9:0]  out_col;
      logic        frame_end;
   } edge_result_type;

   edge_result_type edge_q[$];

   // mirror of the block's state
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   logic [23:0] upper_line [1024];
   logic [23:0] middle_line [1024];
   logic [23:0] left_col [3];    // column c-2: top, mid, bottom
   logic [23:0] mid_col [3];     // column c-1
   int unsigned row_pos, col_pos;

   // floor square root clamped to 255
   function automatic logic [7:0] clamped_root(int unsigned s);
      int unsigned r;
      if (s >= 65536) return 8'd255;
      r = 0;
      for (int b = 14; b >= 0; b--)
         if ((r | (1 << b)) * (r | (1 << b)) <= s) r = r | (1 << b);
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   // prewitt magnitude of one channel; sh selects the byte
   function automatic logic [7:0] prewitt_mag(logic [23:0] c0 [3], logic [23:0] c1 [3],
                                              logic [23:0] c2 [3], int sh);
      int gx, gy;
      gx = 0;
      for (int k = 0; k < 3; k++)
         gx += int'((c2[k] >> sh) & 8'hff) - int'((c0[k] >> sh) & 8'hff);
      gy = int'((c0[2] >> sh) & 8'hff) + int'((c1[2] >> sh) & 8'hff)
         + int'((c2[2] >> sh) & 8'hff) - int'((c0[0] >> sh) & 8'hff)
         - int'((c1[0] >> sh) & 8'hff) - int'((c2[0] >> sh) & 8'hff);
      return clamped_root(int'(gx * gx + gy * gy));
   endfunction

   // advance the mirror by one pixel and queue the result it causes
   function automatic void take_pixel(logic [23:0] px);
      int unsigned w, h, idx;
      logic [23:0] cur [3];
      edge_result_type e;
      w = (width_reg < 3) ? 3 : (width_reg > 1024) ? 1024 : width_reg;
      h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
      idx = col_pos % 1024;
      cur[0] = upper_line[idx];
      cur[1] = middle_line[idx];
      cur[2] = px;
      if (row_pos >= 1 && col_pos >= 1) begin
         e.red_edge = 0;
         e.green_edge = 0;
         e.blue_edge = 0;
         // border centers give zero
         if (row_pos - 1 != 0 && col_pos - 1 != 0 && row_pos - 1 < h - 1
             && col_pos - 1 < w - 1) begin
            e.red_edge   = prewitt_mag(left_col, mid_col, cur, 0);
            e.green_edge = prewitt_mag(left_col, mid_col, cur, 8);
            e.blue_edge  = prewitt_mag(left_col, mid_col, cur, 16);
         end
         e.out_row = 12'(row_pos - 1);
         e.out_col = 10'(col_pos - 1);
         e.frame_end = (row_pos == h - 1 && col_pos == w - 1);
         edge_q.push_back(e);
      end
      left_col = mid_col;
      mid_col = cur;
      upper_line[idx] = cur[1];
      middle_line[idx] = px;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   always @(posedge clock) begin
      edge_result_type e;
      if (reset) begin
         width_reg = 640;
         height_reg = 480;
         row_pos = 0;
         col_pos = 0;
         for (int k = 0; k < 3; k++) begin
            left_col[k] = 0;
            mid_col[k] = 0;
         end
         foreach (upper_line[i]) begin
            upper_line[i] = 0;
            middle_line[i] = 0;
         end
         edge_q.delete();
         fail_count = 0;
         result_count = 0;
         frame_end_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) width_reg = csr_wdata[10:0];
            else if (csr_index == CSR_HEIGHT) height_reg = csr_wdata;
         end
         // result compare
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (edge_q.size() == 0) begin
               $error("result with no request pending: %h", rsp_tdata);
               fail_count++;
            end else begin
               e = edge_q.pop_front();
               if (rsp_tdata[7:0] !== e.red_edge) begin
                  $error("red_edge exp %0d got %0d", e.red_edge, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[15:8] !== e.green_edge) begin
                  $error("green_edge exp %0d got %0d", e.green_edge, rsp_tdata[15:8]);
                  fail_count++;
               end
               if (rsp_tdata[23:16] !== e.blue_edge) begin
                  $error("blue_edge exp %0d got %0d", e.blue_edge, rsp_tdata[23:16]);
                  fail_count++;
               end
               if (rsp_tdata[35:24] !== e.out_row) begin
                  $error("out_row exp %0d got %0d", e.out_row, rsp_tdata[35:24]);
                  fail_count++;
               end
               if (rsp_tdata[45:36] !== e.out_col) begin
                  $error("out_col exp %0d got %0d", e.out_col, rsp_tdata[45:36]);
                  fail_count++;
               end
               if (rsp_tlast !== e.frame_end) begin
                  $error("frame_end exp %0d got %0d", e.frame_end, rsp_tlast);
                  fail_count++;
               end
               if (e.frame_end) frame_end_count++;
            end
         end
         // request intake
         if (req_tvalid && req_tready) take_pixel(req_tdata);
      end
      pending_count = edge_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the prewitt rgb edge magnitude block: drives frames of
// pixels and register writes, stalls the result side; depends on pre_pkg,
// prewitt_rgb_edge_magnitude and prewitt_edge_checker
module tb_top;
   import pre_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red_in, green_in, blue_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // red_edge, green_edge, blue_edge, out_row, out_col
   logic        rsp_tlast;   // frame_end
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [12:0] csr_wdata;

   int fail_count, pending_count, result_count, frame_end_count;
   int pixels_sent;
   int frames_sent;
   bit no_idle;             // frame-long stretch without sender gaps
   bit long_hold_armed;

   prewitt_rgb_edge_magnitude DUT (.*);

   prewitt_edge_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int stall_left, r;
      stall_left = 0;
      rsp_tready = 0;
      long_hold_armed = 1;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (long_hold_armed && result_count >= 300) begin
            long_hold_armed = 0;
            stall_left = 400;
            rsp_tready <= 0;
         end else begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 70) begin
               rsp_tready <= 1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 3);
               rsp_tready <= 0;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_tready <= 0;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // one pixel request, with a random gap in front
   task automatic send_pixel(logic [23:0] px);
      int r, gap;
      r = $urandom_range(0, 99);
      gap = (no_idle || r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                               : $urandom_range(8, 40);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait for the block to drain, then write one register
   task automatic write_reg(logic [0:0] idx, logic [12:0] val);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // one whole frame; pattern picks the pixel content
   task automatic send_frame(logic [10:0] w_raw, logic [12:0] h_raw, int pattern);
      int w, h;
      logic [23:0] px;
      w = (w_raw < 3) ? 3 : (w_raw > 1024) ? 1024 : w_raw;
      h = (h_raw < 3) ? 3 : (h_raw > 4096) ? 4096 : h_raw;
      for (int rr = 0; rr < h; rr++)
         for (int cc = 0; cc < w; cc++) begin
            case (pattern)
               0: px = 24'($urandom);
               1: for (int k = 0; k < 24; k += 8)   // saturating 0/255 per channel
                     px[k +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
               2: px = {6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
               3: px = (cc == 0) ? 24'h000000 : 24'hffffff;  // vertical step
               default: px = (rr == 0) ? 24'hffffff : 24'h000000; // horizontal step
            endcase
            send_pixel(px);
         end
      frames_sent++;
      pixels_sent += w * h;
   endtask

   initial begin
      logic [10:0] w;
      logic [12:0] h;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_we = 0;
      csr_index = CSR_WIDTH;
      csr_wdata = 0;
      no_idle = 0;
      frames_sent = 0;
      pixels_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: smallest frame, step edges and saturation
      write_reg(CSR_WIDTH, 13'd3);
      write_reg(CSR_HEIGHT, 13'd3);
      send_frame(11'd3, 13'd3, 3);
      send_frame(11'd3, 13'd3, 4);
      send_frame(11'd3, 13'd3, 1);

      // sizes below the minimum clamp up to 3x3, back to back
      write_reg(CSR_WIDTH, 13'd0);
      write_reg(CSR_HEIGHT, 13'd1);
      no_idle = 1;
      send_frame(11'd0, 13'd1, 2);
      no_idle = 0;

      // random frame sizes and content
      while (pixels_sent < 1150) begin
         w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
                                         : 11'($urandom_range(3, 24));
         h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                         : 13'($urandom_range(3, 12));
         write_reg(CSR_WIDTH, 13'(w));
         write_reg(CSR_HEIGHT, h);
         no_idle = ($urandom_range(0, 4) == 0);
         send_frame(w, h, $urandom_range(0, 4));
      end
      no_idle = 0;

      // drain
      req_tvalid <= 0;
      @(posedge clock);
      for (int n = 0; n < IDLE_LIMIT && pending_count != 0; n++) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d frames, %0d pixels, %0d results checked, %0d frame ends",
               frames_sent, pixels_sent, result_count, frame_end_count);
      $display("sizes from 3x3 to 24x12, low size clamps, one long output stall");
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== prewitt_rgb_edge_magnitude.f =====
rtl/pre_pkg.sv
rtl/pre_ctrl.sv
rtl/pre_dp.sv
rtl/prewitt_rgb_edge_magnitude.sv
rtl/pre_check.sv
tb/prewitt_edge_checker.sv
tb/tb_top.sv
